// ===== rtl/srfp_pkg.sv =====
// ----------------------------------------------------------------------------
// srfp_pkg
// Shared types, constants and the quarter-sine table of the sine-ramped force
// profile unit.
// ----------------------------------------------------------------------------
`default_nettype none

package srfp_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int STEP_COUNT_BITS = 16;

  localparam int TBL_SIZE = (1 << SINE_TABLE_BITS) + 1;
  localparam int CNT_W    = STEP_COUNT_BITS;
  localparam int ANGLE_W  = 17;
  localparam int TIME_W   = 62;
  localparam int FORCE_W  = 16;
  localparam int ENTRY_W  = 16;
  localparam int TSTEP_W  = 30;

  localparam logic [ANGLE_W-1:0] QUARTER        = ANGLE_W'(65536);
  localparam logic [63:0]        HALF_PI_Q30    = 64'd1686629713;
  localparam logic [TSTEP_W-1:0] TSTEP_RESET    = TSTEP_W'(10000000);

  typedef logic [TIME_W-1:0] time_t;
  typedef logic signed [FORCE_W-1:0] force_t;
  typedef logic [TBL_SIZE-1:0][ENTRY_W-1:0] sine_tbl_t;

  typedef enum logic [1:0] {
    SEG_RISE = 2'd0,
    SEG_HOLD = 2'd1,
    SEG_FALL = 2'd2
  } seg_e;

  typedef enum logic [2:0] {
    REG_FORCE_X      = 3'd0,
    REG_FORCE_Y      = 3'd1,
    REG_FORCE_Z      = 3'd2,
    REG_RAMP_STEPS   = 3'd3,
    REG_FULL_STEPS   = 3'd4,
    REG_TIME_STEP_NS = 3'd5,
    REG_PHASE_STEP   = 3'd6
  } reg_idx_e;

  // Quarter-sine in Q15, built from a Q30 Taylor series at elaboration.
  function automatic sine_tbl_t build_sine_tbl();
    sine_tbl_t   tbl;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    for (int k = 0; k < TBL_SIZE; k++) begin
      x    = (64'(k) * HALF_PI_Q30) >> SINE_TABLE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if ((n % 2) == 1) begin
          sum = (sum >= term) ? sum - term : 64'd0;
        end else begin
          sum = sum + term;
        end
      end
      v = (sum * 64'd32768 + (64'd1 << 29)) >> 30;
      if (v > 64'd32768) begin
        v = 64'd32768;
      end
      tbl[k] = v[ENTRY_W-1:0];
    end
    return tbl;
  endfunction

  localparam sine_tbl_t SINE_TBL = build_sine_tbl();

endpackage

`default_nettype wire

// ===== rtl/srfp_if.sv =====
// ----------------------------------------------------------------------------
// srfp_if
// Valid/ready channels of the force profile unit: request in, sample out.
// ----------------------------------------------------------------------------
`default_nettype none

interface srfp_req_if import srfp_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  req_type;
  time_t start_time_ns;

  modport source (output valid, output req_type, output start_time_ns, input ready);
  modport sink   (input valid, input req_type, input start_time_ns, output ready);
endinterface

interface srfp_smp_if import srfp_pkg::*; ();
  logic       valid;
  logic       ready;
  force_t     out_force_x;
  force_t     out_force_y;
  force_t     out_force_z;
  time_t      sample_time_ns;
  logic [1:0] segment;
  logic       last;

  modport source (output valid, output out_force_x, output out_force_y,
                  output out_force_z, output sample_time_ns, output segment,
                  output last, input ready);
  modport sink   (input valid, input out_force_x, input out_force_y,
                  input out_force_z, input sample_time_ns, input segment,
                  input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/sine_ramped_force_profile_unit.sv =====
// ----------------------------------------------------------------------------
// sine_ramped_force_profile_unit
// Three-axis force profile: sine rise, hold at full force, mirrored sine fall.
// ----------------------------------------------------------------------------
// A start item (req_type 0) loads the base timestamp and arms the profile; it
// produces no sample. Each tick item (req_type 1) while armed produces one
// sample whose timestamp is one time step later (saturating at 2^62-1). The
// rise lasts the ramp length in samples at angle i*phase_step (65536 = pi/2),
// the hold lasts the hold length at full force, the fall lasts the ramp length
// again at angle 65536 - i*phase_step; empty segments are skipped and last
// flags the final sample. One item is accepted every cycle while the output
// is not stalled: the profile state advances in the accept cycle, the
// quarter-sine ROM is read into a registered stage, and the three force
// products are formed into the output register. Ticks while idle are dropped.
// Configure the registers over APB only while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_ramped_force_profile_unit import srfp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  srfp_req_if.sink         req_i,
  srfp_smp_if.source       smp_o
);

  // Configuration registers
  force_t               force_x_q, force_y_q, force_z_q;
  logic [15:0]          ramp_q, full_q;
  logic [TSTEP_W-1:0]   tstep_q;
  logic [ANGLE_W-1:0]   phase_q;

  // Profile state
  logic                 active_q;
  seg_e                 seg_q;
  logic [CNT_W-1:0]     step_q;
  logic [ANGLE_W-1:0]   acc_q;
  time_t                rtime_q;

  // Sample stage and output register
  logic                 s1_valid_q;
  logic [ENTRY_W-1:0]   s1_entry_q;
  time_t                s1_time_q;
  seg_e                 s1_seg_q;
  logic                 s1_last_q;
  logic                 out_valid_q;
  force_t               out_fx_q, out_fy_q, out_fz_q;
  time_t                out_time_q;
  seg_e                 out_seg_q;
  logic                 out_last_q;

  logic                 cfg_wr;
  logic                 out_free;
  logic                 in_fire;
  logic                 is_tick;
  logic [CNT_W-1:0]     len_ramp, len_full, e_len;
  seg_e                 e_seg;
  logic [CNT_W-1:0]     e_step, n_step;
  logic [ANGLE_W-1:0]   e_acc, ang_cl, angle, ps_cl, n_acc;
  logic [ANGLE_W:0]     acc_sum;
  logic                 e_done;
  logic                 emit;
  logic                 more;
  logic [SINE_TABLE_BITS:0] tbl_idx;
  logic [TIME_W:0]      t_sum;
  time_t                t_next;

  // ---------------------------------------------------------------------------
  // APB register file
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      force_x_q <= '0;
      force_y_q <= '0;
      force_z_q <= '0;
      ramp_q    <= '0;
      full_q    <= '0;
      tstep_q   <= TSTEP_RESET;
      phase_q   <= '0;
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[4:2]))
        REG_FORCE_X:      force_x_q <= force_t'(pwdata[15:0]);
        REG_FORCE_Y:      force_y_q <= force_t'(pwdata[15:0]);
        REG_FORCE_Z:      force_z_q <= force_t'(pwdata[15:0]);
        REG_RAMP_STEPS:   ramp_q    <= pwdata[15:0];
        REG_FULL_STEPS:   full_q    <= pwdata[15:0];
        REG_TIME_STEP_NS: tstep_q   <= pwdata[TSTEP_W-1:0];
        REG_PHASE_STEP:   phase_q   <= pwdata[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[4:2]))
      REG_FORCE_X:      prdata = 32'($unsigned(force_x_q));
      REG_FORCE_Y:      prdata = 32'($unsigned(force_y_q));
      REG_FORCE_Z:      prdata = 32'($unsigned(force_z_q));
      REG_RAMP_STEPS:   prdata = 32'(ramp_q);
      REG_FULL_STEPS:   prdata = 32'(full_q);
      REG_TIME_STEP_NS: prdata = 32'(tstep_q);
      REG_PHASE_STEP:   prdata = 32'(phase_q);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: hold the input while a sample sits in the stage and the output
  // register cannot take it.
  // ---------------------------------------------------------------------------
  assign out_free    = !out_valid_q || smp_o.ready;
  assign req_i.ready = !s1_valid_q || out_free;
  assign in_fire     = req_i.valid && req_i.ready;
  assign is_tick     = req_i.req_type;

  // ---------------------------------------------------------------------------
  // Segment skip: move past segments whose length is used up or zero.
  // ---------------------------------------------------------------------------
  assign len_ramp = CNT_W'(ramp_q);
  assign len_full = CNT_W'(full_q);

  always_comb begin
    e_seg  = seg_q;
    e_step = step_q;
    e_acc  = acc_q;
    e_done = 1'b0;
    case (seg_q)
      SEG_RISE: begin
        if (step_q >= len_ramp) begin
          e_step = '0;
          e_acc  = '0;
          if (len_full != '0) begin
            e_seg = SEG_HOLD;
          end else if (len_ramp != '0) begin
            e_seg = SEG_FALL;
          end else begin
            e_done = 1'b1;
          end
        end
      end
      SEG_HOLD: begin
        if (step_q >= len_full) begin
          e_step = '0;
          e_acc  = '0;
          if (len_ramp != '0) begin
            e_seg = SEG_FALL;
          end else begin
            e_done = 1'b1;
          end
        end
      end
      SEG_FALL: begin
        if (step_q >= len_ramp) begin
          e_done = 1'b1;
        end
      end
      default: e_done = 1'b1;
    endcase
  end

  // Angle for this sample and the table address
  always_comb begin
    ang_cl = (e_acc > QUARTER) ? QUARTER : e_acc;
    case (e_seg)
      SEG_HOLD: angle = QUARTER;
      SEG_FALL: angle = QUARTER - ang_cl;
      default:  angle = ang_cl;
    endcase
  end
  assign tbl_idx = angle[ANGLE_W-1 -: SINE_TABLE_BITS + 1];

  // Saturating timestamp
  assign t_sum  = {1'b0, rtime_q} + (TIME_W + 1)'(tstep_q);
  assign t_next = t_sum[TIME_W] ? '1 : t_sum[TIME_W-1:0];

  // Advance step and angle; find out whether anything is left after this one
  assign n_step  = e_step + 1'b1;
  assign ps_cl   = (phase_q > QUARTER) ? QUARTER : phase_q;
  assign acc_sum = {1'b0, e_acc} + {1'b0, ps_cl};
  assign e_len   = (e_seg == SEG_HOLD) ? len_full : len_ramp;

  always_comb begin
    if (e_seg == SEG_HOLD) begin
      n_acc = e_acc;
    end else if (acc_sum > {1'b0, QUARTER}) begin
      n_acc = QUARTER;
    end else begin
      n_acc = acc_sum[ANGLE_W-1:0];
    end
    more = (n_step < e_len) && (n_step != '0);
    case (e_seg)
      SEG_RISE: more = more || (len_full != '0) || (len_ramp != '0);
      SEG_HOLD: more = more || (len_ramp != '0);
      default:  ;
    endcase
  end

  assign emit = is_tick && active_q && !e_done;

  // ---------------------------------------------------------------------------
  // Profile state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      seg_q    <= SEG_RISE;
      step_q   <= '0;
      acc_q    <= '0;
      rtime_q  <= '0;
    end else if (in_fire) begin
      if (!is_tick) begin
        // Start: reload everything, arm only if the profile is not empty
        rtime_q  <= req_i.start_time_ns;
        seg_q    <= SEG_RISE;
        step_q   <= '0;
        acc_q    <= '0;
        active_q <= (len_ramp != '0) || (len_full != '0);
      end else if (active_q) begin
        if (emit) begin
          rtime_q <= t_next;
        end
        if (emit && more) begin
          seg_q  <= e_seg;
          step_q <= n_step;
          acc_q  <= n_acc;
        end else begin
          active_q <= 1'b0;
          seg_q    <= SEG_RISE;
          step_q   <= '0;
          acc_q    <= '0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sample stage: registered ROM read
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= in_fire && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready) begin
      s1_entry_q <= SINE_TBL[tbl_idx];
      s1_time_q  <= t_next;
      s1_seg_q   <= e_seg;
      s1_last_q  <= !more;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: scale each axis by the shared sine value
  // ---------------------------------------------------------------------------
  function automatic force_t scale_force(input force_t f, input logic [ENTRY_W-1:0] e);
    logic signed [ENTRY_W:0]  es;
    logic signed [32:0]       p;
    logic signed [17:0]       r;
    es = $signed({1'b0, e});
    p  = 33'(f) * 33'(es);
    p  = p + 33'sd16384;
    r  = 18'(p >>> 15);
    if (r > 18'sd32767) begin
      return 16'sh7FFF;
    end else if (r < -18'sd32768) begin
      return 16'sh8000;
    end
    return force_t'(r[FORCE_W-1:0]);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_valid_q) begin
      out_fx_q   <= scale_force(force_x_q, s1_entry_q);
      out_fy_q   <= scale_force(force_y_q, s1_entry_q);
      out_fz_q   <= scale_force(force_z_q, s1_entry_q);
      out_time_q <= s1_time_q;
      out_seg_q  <= s1_seg_q;
      out_last_q <= s1_last_q;
    end
  end

  assign smp_o.valid          = out_valid_q;
  assign smp_o.out_force_x    = out_fx_q;
  assign smp_o.out_force_y    = out_fy_q;
  assign smp_o.out_force_z    = out_fz_q;
  assign smp_o.sample_time_ns = out_time_q;
  assign smp_o.segment        = out_seg_q;
  assign smp_o.last           = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Idle profile always parks at the start of the rise.
  a_idle_parked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (seg_q == SEG_RISE) && (step_q == '0))
    else $error("idle profile not parked at start of rise");

  // A start item never produces a sample.
  a_start_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !is_tick) |=> !s1_valid_q)
    else $error("start item produced a sample");

  // The final sample disarms the profile.
  a_last_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && emit && !more) |=> !active_q)
    else $error("profile still armed after final sample");

  // Timestamps never go backwards within a profile.
  a_time_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && emit) |=> (rtime_q >= $past(rtime_q)))
    else $error("sample timestamp decreased");

endmodule

`default_nettype wire
